// ----- design/pcfs_pkg.sv -----
// Shared types and constants for the point cloud frame statistics block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package pcfs_pkg;

  // Default coordinate width of the point inputs
  localparam int unsigned COORD_BITS_DEF = 16;

  // Azimuth sectors of 30 degrees each
  localparam int unsigned NUM_SECTORS = 12;

  // Frame snapshots held between the front and the back
  localparam int unsigned QUEUE_DEPTH = 2;

  // One result bit per square root iteration
  localparam int unsigned ROOT_STEPS = 16;

  // Frame clear values
  localparam logic signed [15:0] Z_LOW_CLEAR  = 16'sh7FFF;
  localparam logic signed [15:0] Z_HIGH_CLEAR = 16'sh8000;
  localparam logic [31:0]        RSQ_LOW_CLEAR  = 32'hFFFF_FFFF;
  localparam logic [31:0]        RSQ_HIGH_CLEAR = 32'h0000_0000;
  localparam logic [15:0]        COUNT_MAX      = 16'hFFFF;

  // Statistics of one finished frame, squared ranges not yet rooted
  typedef struct packed {
    logic [15:0]            point_count;
    logic signed [15:0]     z_min;
    logic signed [15:0]     z_max;
    logic [31:0]            rsq_min;
    logic [31:0]            rsq_max;
    logic [NUM_SECTORS-1:0] sector_mask;
    logic [31:0]            frame_number;
  } frame_stats_t;

  // Queue status seen by the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Back sequencer states
  typedef enum logic [1:0] {
    BackIdle,
    BackRoot,
    BackHold
  } back_state_e;

endpackage

// ----- design/pcfs_isqrt.sv -----
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// Depends on pcfs_pkg for the step count.
`timescale 1ns / 1ps

module pcfs_isqrt
  import pcfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] radicand_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  localparam int unsigned STEP_W = $clog2(ROOT_STEPS);

  logic [31:0]       rad_q, rad_d;
  logic [17:0]       rem_q, rem_d;
  logic [15:0]       root_q, root_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;

  logic [19:0] rem_try;
  logic [19:0] trial;
  logic [19:0] rem_sub;

  // One digit step: bring down two radicand bits, try appending a one
  always_comb begin
    rem_try = {rem_q, rad_q[31:30]};
    trial   = {2'b00, root_q, 2'b01};
    rem_sub = rem_try - trial;
  end

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[29:0], 2'b00};
      if (rem_try >= trial) begin
        rem_d  = rem_sub[17:0];
        root_d = {root_q[14:0], 1'b1};
      end else begin
        rem_d  = rem_try[17:0];
        root_d = {root_q[14:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = !busy_q;
  assign root_o = root_q;

endmodule

// ----- design/pcfs_front.sv -----
// Front of the frame statistics block: accepts points, squares and classifies
// them in a short pipeline and folds them into the frame accumulators.
// Depends on pcfs_pkg; pushes finished frames into pcfs_queue.
`timescale 1ns / 1ps

module pcfs_front
  import pcfs_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] x_mm_i,
  input  logic signed [COORD_BITS-1:0] y_mm_i,
  input  logic signed [COORD_BITS-1:0] z_mm_i,
  input  logic                         frame_last_i,
  input  queue_status_t                queue_status_i,
  output logic                         push_o,
  output frame_stats_t                 push_data_o
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned PW  = 2 * CB;
  localparam int unsigned TW  = 2 * CB + 2;
  localparam int unsigned SW  = (TW > 33) ? TW : 33;
  localparam int unsigned ZW  = (CB > 16) ? CB : 17;

  logic adv;

  // Stage 1: captured point and its quadrant
  logic                 s1_valid_q;
  logic signed [CB-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                 s1_last_q;
  logic [1:0]           s1_quad_q;
  logic                 s1_origin_q;
  logic [1:0]           quad_d;

  // Stage 2: squares and saturated z
  logic                 s2_valid_q;
  logic [PW-1:0]        s2_xx_q, s2_yy_q, s2_zz_q;
  logic signed [15:0]   s2_z_q;
  logic                 s2_last_q;
  logic [1:0]           s2_quad_q;
  logic                 s2_origin_q;

  // Stage 3: squared range and sector mark
  logic                   s3_valid_q;
  logic [31:0]            s3_rsq_q;
  logic signed [15:0]     s3_z_q;
  logic [NUM_SECTORS-1:0] s3_mark_q;
  logic                   s3_last_q;

  // Frame accumulators
  logic signed [15:0]     z_low_q, z_low_d;
  logic signed [15:0]     z_high_q, z_high_d;
  logic [31:0]            rsq_low_q, rsq_low_d;
  logic [31:0]            rsq_high_q, rsq_high_d;
  logic [NUM_SECTORS-1:0] marks_q, marks_d;
  logic [15:0]            tally_q, tally_d;
  logic [31:0]            frame_q, frame_d;

  // Whole pipeline holds while a frame end waits for queue space
  assign adv        = !(s3_valid_q && s3_last_q && queue_status_i.full);
  assign in_stall_o = !adv;

  // Quadrant from the signs; quadrant boundaries go to the next quadrant counterclockwise
  always_comb begin
    if (x_mm_i > 0 && y_mm_i >= 0) begin
      quad_d = 2'd0;
    end else if (x_mm_i <= 0 && y_mm_i > 0) begin
      quad_d = 2'd1;
    end else if (x_mm_i < 0 && y_mm_i <= 0) begin
      quad_d = 2'd2;
    end else begin
      quad_d = 2'd3;
    end
  end

  // Stage 2 arithmetic
  logic signed [PW-1:0] x_ext, y_ext, z_ext;
  logic signed [ZW-1:0] z_wide;
  logic signed [15:0]   z_sat;

  always_comb begin
    x_ext  = PW'(s1_x_q);
    y_ext  = PW'(s1_y_q);
    z_ext  = PW'(s1_z_q);
    z_wide = ZW'(s1_z_q);
    if (z_wide > $signed(ZW'(32767))) begin
      z_sat = 16'sh7FFF;
    end else if (z_wide < -$signed(ZW'(32768))) begin
      z_sat = 16'sh8000;
    end else begin
      z_sat = 16'(z_wide);
    end
  end

  // Stage 3 arithmetic: range sum with saturation, sector compares
  logic [SW-1:0]          rsq_sum;
  logic [31:0]            rsq_sat;
  logic [TW-1:0]          uu, vv, uu3, vv3;
  logic [1:0]             sec_off;
  logic [3:0]             sec_idx;
  logic [NUM_SECTORS-1:0] mark_d;

  always_comb begin
    rsq_sum = SW'(s2_xx_q) + SW'(s2_yy_q) + SW'(s2_zz_q);
    rsq_sat = (|rsq_sum[SW-1:32]) ? 32'hFFFF_FFFF : rsq_sum[31:0];

    // Odd quadrants swap the roles of x and y after rotation
    uu  = s2_quad_q[0] ? TW'(s2_yy_q) : TW'(s2_xx_q);
    vv  = s2_quad_q[0] ? TW'(s2_xx_q) : TW'(s2_yy_q);
    uu3 = (uu << 1) + uu;
    vv3 = (vv << 1) + vv;
    if (vv >= uu3) begin
      sec_off = 2'd2;
    end else if (vv3 >= uu) begin
      sec_off = 2'd1;
    end else begin
      sec_off = 2'd0;
    end
    sec_idx = ({2'b00, s2_quad_q} << 1) + {2'b00, s2_quad_q} + {2'b00, sec_off};
    // Origin in the plane counts as azimuth zero
    if (s2_origin_q) begin
      mark_d = NUM_SECTORS'(1);
    end else begin
      mark_d = NUM_SECTORS'(1) << sec_idx;
    end
  end

  // Accumulator update and frame end
  logic fold;
  logic frame_end;

  always_comb begin
    fold      = s3_valid_q && adv;
    frame_end = fold && s3_last_q;

    z_low_d    = (s3_z_q < z_low_q)    ? s3_z_q   : z_low_q;
    z_high_d   = (s3_z_q > z_high_q)   ? s3_z_q   : z_high_q;
    rsq_low_d  = (s3_rsq_q < rsq_low_q)  ? s3_rsq_q : rsq_low_q;
    rsq_high_d = (s3_rsq_q > rsq_high_q) ? s3_rsq_q : rsq_high_q;
    marks_d    = marks_q | s3_mark_q;
    tally_d    = (tally_q == COUNT_MAX) ? tally_q : tally_q + 16'd1;
    frame_d    = frame_q + 32'd1;

    push_o                   = frame_end;
    push_data_o.point_count  = tally_d;
    push_data_o.z_min        = z_low_d;
    push_data_o.z_max        = z_high_d;
    push_data_o.rsq_min      = rsq_low_d;
    push_data_o.rsq_max      = rsq_high_d;
    push_data_o.sector_mask  = marks_d;
    push_data_o.frame_number = frame_d;
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q      <= x_mm_i;
      s1_y_q      <= y_mm_i;
      s1_z_q      <= z_mm_i;
      s1_last_q   <= frame_last_i;
      s1_quad_q   <= quad_d;
      s1_origin_q <= (x_mm_i == '0) && (y_mm_i == '0);

      s2_xx_q     <= $unsigned(x_ext * x_ext);
      s2_yy_q     <= $unsigned(y_ext * y_ext);
      s2_zz_q     <= $unsigned(z_ext * z_ext);
      s2_z_q      <= z_sat;
      s2_last_q   <= s1_last_q;
      s2_quad_q   <= s1_quad_q;
      s2_origin_q <= s1_origin_q;

      s3_rsq_q    <= rsq_sat;
      s3_z_q      <= s2_z_q;
      s3_mark_q   <= mark_d;
      s3_last_q   <= s2_last_q;
    end
  end

  // Frame accumulators, cleared after each frame end; the frame counter advances instead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_low_q    <= Z_LOW_CLEAR;
      z_high_q   <= Z_HIGH_CLEAR;
      rsq_low_q  <= RSQ_LOW_CLEAR;
      rsq_high_q <= RSQ_HIGH_CLEAR;
      marks_q    <= '0;
      tally_q    <= '0;
      frame_q    <= '0;
    end else if (frame_end) begin
      z_low_q    <= Z_LOW_CLEAR;
      z_high_q   <= Z_HIGH_CLEAR;
      rsq_low_q  <= RSQ_LOW_CLEAR;
      rsq_high_q <= RSQ_HIGH_CLEAR;
      marks_q    <= '0;
      tally_q    <= '0;
      frame_q    <= frame_d;
    end else if (fold) begin
      z_low_q    <= z_low_d;
      z_high_q   <= z_high_d;
      rsq_low_q  <= rsq_low_d;
      rsq_high_q <= rsq_high_d;
      marks_q    <= marks_d;
      tally_q    <= tally_d;
    end
  end

endmodule

// ----- design/pcfs_queue.sv -----
// Short queue of finished frame snapshots between the front and the back.
// Depends on pcfs_pkg for the snapshot type and depth.
`timescale 1ns / 1ps

module pcfs_queue
  import pcfs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  frame_stats_t  push_data_i,
  input  logic          pop_i,
  output queue_status_t status_o,
  output frame_stats_t  head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_stats_t     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/pcfs_back.sv -----
// Back of the frame statistics block: takes frame snapshots from the queue,
// roots the range bounds, counts sectors and holds the result for the receiver.
// Depends on pcfs_pkg and pcfs_isqrt.
`timescale 1ns / 1ps

module pcfs_back
  import pcfs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  queue_status_t          queue_status_i,
  input  frame_stats_t           head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [15:0]            point_count_o,
  output logic signed [15:0]     z_min_o,
  output logic signed [15:0]     z_max_o,
  output logic [15:0]            range_min_o,
  output logic [15:0]            range_max_o,
  output logic [NUM_SECTORS-1:0] sector_mask_o,
  output logic [3:0]             sectors_covered_o,
  output logic [31:0]            frame_number_o
);

  function automatic logic [3:0] count_ones(input logic [NUM_SECTORS-1:0] m);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < NUM_SECTORS; k++) begin
      c = c + {3'b000, m[k]};
    end
    return c;
  endfunction

  back_state_e state_q, state_d;
  logic        start;
  logic        min_done, max_done;

  // Result registers
  logic [15:0]            count_q;
  logic signed [15:0]     z_min_q, z_max_q;
  logic [NUM_SECTORS-1:0] mask_q;
  logic [3:0]             covered_q;
  logic [31:0]            frame_q;

  pcfs_isqrt u_root_min (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .radicand_i (head_i.rsq_min),
    .done_o     (min_done),
    .root_o     (range_min_o)
  );

  pcfs_isqrt u_root_max (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .radicand_i (head_i.rsq_max),
    .done_o     (max_done),
    .root_o     (range_max_o)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BackIdle: begin
        if (!queue_status_i.empty) begin
          state_d = BackRoot;
        end
      end
      BackRoot: begin
        if (min_done && max_done) begin
          state_d = BackHold;
        end
      end
      BackHold: begin
        if (!out_stall_i) begin
          state_d = BackIdle;
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_o       = 1'b0;
    start       = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      BackIdle: begin
        pop_o = !queue_status_i.empty;
        start = !queue_status_i.empty;
      end
      BackHold: begin
        out_valid_o = 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the snapshot fields that need no rooting
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      count_q   <= head_i.point_count;
      z_min_q   <= head_i.z_min;
      z_max_q   <= head_i.z_max;
      mask_q    <= head_i.sector_mask;
      covered_q <= count_ones(head_i.sector_mask);
      frame_q   <= head_i.frame_number;
    end
  end

  assign point_count_o     = count_q;
  assign z_min_o           = z_min_q;
  assign z_max_o           = z_max_q;
  assign sector_mask_o     = mask_q;
  assign sectors_covered_o = covered_q;
  assign frame_number_o    = frame_q;

endmodule

// ----- design/point_cloud_frame_statistics.sv -----
// Per-frame statistics over a stream of lidar points.
// Usage: points enter on the input channel (in_valid_i / in_stall_o), one per
// cycle while in_stall_o is low; frame_last_i marks the final point of a frame,
// which is part of that frame. Only the final point of a frame causes a result.
// Results leave on the output channel (out_valid_o / out_stall_i): point count,
// z bounds, floor square roots of the squared range bounds, sector mask, sector
// count and frame number starting at 1.
// A frame's last point passes the stage 1, 2 and 3 registers before it reaches
// the accumulators; the result then waits on the two 16-step square root units
// in the back, which run once per frame. Points are taken one per cycle while
// in_stall_o is low. The back works on one frame at a time and pops the next
// only after the receiver takes the result; two finished frames can wait in the
// queue, and only when it is full does a frame end hold the input (in_stall_o).
// Stalling the output holds the result and its fields unchanged.
// Reset clears all frame statistics and the frame counter; no clearing pass.
// Depends on pcfs_pkg, pcfs_front, pcfs_queue, pcfs_back and pcfs_isqrt.
`timescale 1ns / 1ps

module point_cloud_frame_statistics
  import pcfs_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] x_mm_i,
  input  logic signed [COORD_BITS-1:0] y_mm_i,
  input  logic signed [COORD_BITS-1:0] z_mm_i,
  input  logic                         frame_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [15:0]                  point_count_o,
  output logic signed [15:0]           z_min_o,
  output logic signed [15:0]           z_max_o,
  output logic [15:0]                  range_min_o,
  output logic [15:0]                  range_max_o,
  output logic [NUM_SECTORS-1:0]       sector_mask_o,
  output logic [3:0]                   sectors_covered_o,
  output logic [31:0]                  frame_number_o
);

  logic          push;
  frame_stats_t  push_data;
  logic          pop;
  queue_status_t queue_status;
  frame_stats_t  head;

  pcfs_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .x_mm_i         (x_mm_i),
    .y_mm_i         (y_mm_i),
    .z_mm_i         (z_mm_i),
    .frame_last_i   (frame_last_i),
    .queue_status_i (queue_status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  pcfs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .status_o    (queue_status),
    .head_o      (head)
  );

  pcfs_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .queue_status_i    (queue_status),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .point_count_o     (point_count_o),
    .z_min_o           (z_min_o),
    .z_max_o           (z_max_o),
    .range_min_o       (range_min_o),
    .range_max_o       (range_max_o),
    .sector_mask_o     (sector_mask_o),
    .sectors_covered_o (sectors_covered_o),
    .frame_number_o    (frame_number_o)
  );

endmodule
